/* rtl/gbp_pkg.sv */
// Shared types, widths and codes of the gradient background pixel core.
package gbp_pkg;

   localparam int COORD_BITS_DEF = 12;   // default coordinate bits used
   localparam int CW             = 12;   // coordinate port width
   localparam int SW             = 13;   // size register width
   localparam int RGB_W          = 24;   // packed color width
   localparam int CSR_IDX_W      = 3;    // register index width
   localparam int CSR_DATA_W     = 24;   // widest register
   localparam int DEN_W          = 39;   // dividend / divisor width
   localparam int QUO_W          = 32;   // quotient bits
   localparam int ROOT_W         = 16;   // square root bits
   localparam int T_W            = 17;   // blend factor, 1.0 = 65536
   localparam logic [T_W-1:0] T_ONE = 17'h10000;

   // Fill mode codes.
   localparam logic [2:0] MODE_SOLID        = 3'd0;
   localparam logic [2:0] MODE_TOP_BOTTOM   = 3'd1;
   localparam logic [2:0] MODE_BOTTOM_TOP   = 3'd2;
   localparam logic [2:0] MODE_LEFT_RIGHT   = 3'd3;
   localparam logic [2:0] MODE_RIGHT_LEFT   = 3'd4;
   localparam logic [2:0] MODE_RADIAL       = 3'd5;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SOLID_RGB    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_RGB    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_RGB   = 3'd5;

   typedef struct packed {
      logic [CW-1:0] pixel_x;
      logic [CW-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   // Per-request control that rides along the arithmetic pipelines.
   typedef struct packed {
      logic [2:0] mode;
      logic       t_zero;
      logic       t_one;
   } side_type;

endpackage

/* rtl/gbp_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage.
module gbp_div_pipe
   import gbp_pkg::*;
#(
   parameter int STEPS = QUO_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [DEN_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  side_type          in_side,
   output logic              out_valid,
   output logic [STEPS-1:0]  out_quo,
   output side_type          out_side
);

   logic             valid_ff [STEPS];
   logic [DEN_W-1:0] rem_ff   [STEPS];
   logic [DEN_W-1:0] den_ff   [STEPS];
   logic [STEPS-1:0] quo_ff   [STEPS];
   side_type         side_ff  [STEPS];

   logic             valid_in [STEPS];
   logic [DEN_W-1:0] rem_in   [STEPS];
   logic [DEN_W-1:0] den_in   [STEPS];
   logic [STEPS-1:0] quo_in   [STEPS];
   side_type         side_in  [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic             v_src;
      logic [DEN_W-1:0] r_src;
      logic [DEN_W-1:0] d_src;
      logic [STEPS-1:0] q_src;
      side_type         s_src;
      logic [DEN_W:0]   shifted;
      logic             fits;

      if (k == 0) begin : g_first
         assign v_src = in_valid;
         assign r_src = in_num;
         assign d_src = in_den;
         assign q_src = '0;
         assign s_src = in_side;
      end else begin : g_next
         assign v_src = valid_ff[k-1];
         assign r_src = rem_ff[k-1];
         assign d_src = den_ff[k-1];
         assign q_src = quo_ff[k-1];
         assign s_src = side_ff[k-1];
      end

      assign shifted     = {r_src, 1'b0};
      assign fits        = shifted >= {1'b0, d_src};
      assign valid_in[k] = v_src;
      assign rem_in[k]   = fits ? DEN_W'(shifted - {1'b0, d_src}) : shifted[DEN_W-1:0];
      assign den_in[k]   = d_src;
      assign quo_in[k]   = {q_src[STEPS-2:0], fits};
      assign side_in[k]  = s_src;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STEPS; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STEPS; k++) begin
         rem_ff[k]  <= rem_in[k];
         den_ff[k]  <= den_in[k];
         quo_ff[k]  <= quo_in[k];
         side_ff[k] <= side_in[k];
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_quo   = quo_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

   // The last stage, when valid with a nonzero divisor, keeps its partial remainder below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[STEPS-1] && (den_ff[STEPS-1] != '0)) |->
         rem_ff[STEPS-1] < den_ff[STEPS-1])
      else $error("divider remainder not below divisor");

endmodule

/* rtl/gbp_sqrt_pipe.sv */
// Pipelined digit-by-digit integer square root, one root bit per stage.
module gbp_sqrt_pipe
   import gbp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [QUO_W-1:0]  in_val,
   input  side_type          in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output logic [QUO_W-1:0]  out_val,
   output side_type          out_side
);

   localparam int RW = ROOT_W + 3;

   logic              valid_ff [ROOT_W];
   logic [RW-1:0]     rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [QUO_W-1:0]  val_ff   [ROOT_W];
   side_type          side_ff  [ROOT_W];

   logic              valid_in [ROOT_W];
   logic [RW-1:0]     rem_in   [ROOT_W];
   logic [ROOT_W-1:0] root_in  [ROOT_W];
   logic [QUO_W-1:0]  val_in   [ROOT_W];
   side_type          side_in  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      logic              v_src;
      logic [RW-1:0]     r_src;
      logic [ROOT_W-1:0] q_src;
      logic [QUO_W-1:0]  x_src;
      side_type          s_src;
      logic [RW-1:0]     shifted;
      logic [RW-1:0]     trial;
      logic              fits;

      if (k == 0) begin : g_first
         assign v_src = in_valid;
         assign r_src = '0;
         assign q_src = '0;
         assign x_src = in_val;
         assign s_src = in_side;
      end else begin : g_next
         assign v_src = valid_ff[k-1];
         assign r_src = rem_ff[k-1];
         assign q_src = root_ff[k-1];
         assign x_src = val_ff[k-1];
         assign s_src = side_ff[k-1];
      end

      // Bring down the next two bits of the radicand, most significant first.
      assign shifted     = {r_src[RW-3:0], x_src[QUO_W-1-2*k -: 2]};
      assign trial       = {1'b0, q_src, 2'b01};
      assign fits        = shifted >= trial;
      assign valid_in[k] = v_src;
      assign rem_in[k]   = fits ? shifted - trial : shifted;
      assign root_in[k]  = {q_src[ROOT_W-2:0], fits};
      assign val_in[k]   = x_src;
      assign side_in[k]  = s_src;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ROOT_W; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ROOT_W; k++) begin
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
         val_ff[k]  <= val_in[k];
         side_ff[k] <= side_in[k];
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_val   = val_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

   // The root is the floor square root of the radicand.
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (34'(out_root) * 34'(out_root) <= 34'(out_val)) &&
                    ((34'(out_root) + 34'd1) * (34'(out_root) + 34'd1) > 34'(out_val)))
      else $error("square root out of range");

endmodule

/* rtl/gradient_background_pixel_core.sv */
// Top level of the gradient background pixel core: per-pixel background color.
//
// Usage: the raster source drives a pixel coordinate on req_data and raises
// start; the request is taken at each rising edge where start is high and busy
// is low. busy is high only while reset is held, so one request can be taken
// in every clock cycle. Each request yields exactly one color on rsp_data,
// marked by rsp_strobe for one cycle, in request order. A request passes four
// front stages for the offsets and products, the pipelined divider (32 stages,
// one quotient bit each), the square root pipeline (16 stages) and three for
// the blend. Configuration is written through csr_we, csr_index and csr_wdata;
// the user must write it only while no request is in flight, which the block
// itself does not enforce. The derived radial divisor is rebuilt after a write
// through the registered squares, their sum and the scaled product, ahead of
// any request that could need it. A synchronous reset clears the pipeline
// valid bits and loads the register reset values. The receiver cannot stall
// the block: a result must be taken in the cycle in which rsp_strobe is high.
module gradient_background_pixel_core
   import gbp_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_strobe,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Only the low COORD_BITS bits of each coordinate take part.
   localparam logic [CW-1:0] CMASK =
      (COORD_BITS >= CW) ? {CW{1'b1}} : CW'((1 << COORD_BITS) - 1);

   // Configuration registers.
   logic [2:0]       fill_mode_ff;
   logic [SW-1:0]    width_ff;
   logic [SW-1:0]    height_ff;
   logic [RGB_W-1:0] solid_ff;
   logic [RGB_W-1:0] first_ff;
   logic [RGB_W-1:0] second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_mode_ff <= MODE_SOLID;
         width_ff     <= SW'(1);
         height_ff    <= SW'(1);
         solid_ff     <= 24'hFFFFFF;
         first_ff     <= 24'h0000FF;
         second_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FILL_MODE:    fill_mode_ff <= csr_wdata[2:0];
            CSR_IMAGE_WIDTH:  width_ff     <= csr_wdata[SW-1:0];
            CSR_IMAGE_HEIGHT: height_ff    <= csr_wdata[SW-1:0];
            CSR_SOLID_RGB:    solid_ff     <= csr_wdata;
            CSR_FIRST_RGB:    first_ff     <= csr_wdata;
            CSR_SECOND_RGB:   second_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A size of zero counts as one.
   logic [SW-1:0] w_eff, h_eff;
   assign w_eff = (width_ff == '0)  ? SW'(1) : width_ff;
   assign h_eff = (height_ff == '0) ? SW'(1) : height_ff;

   // Radial divisor 2601 * (W*W + H*H), rebuilt from the registers over
   // three register stages. It only changes on configuration writes.
   logic [2*SW-1:0]  wsq_ff, hsq_ff;
   logic [2*SW:0]    whsum_ff;
   logic [DEN_W-1:0] rden_ff;

   always_ff @(posedge clock) begin
      wsq_ff   <= (2*SW)'(w_eff) * (2*SW)'(w_eff);
      hsq_ff   <= (2*SW)'(h_eff) * (2*SW)'(h_eff);
      whsum_ff <= (2*SW+1)'(wsq_ff) + (2*SW+1)'(hsq_ff);
      rden_ff  <= DEN_W'(whsum_ff) * DEN_W'(12'd2601);
   end

   assign busy = reset;

   logic accept;
   assign accept = start && !busy;

   // ---------------------------------------------------------------------
   // Stage 0: mode decode, masked coordinate, span and mirrored offsets.
   // ---------------------------------------------------------------------
   logic [CW-1:0] x_m, y_m;
   assign x_m = req_data.pixel_x & CMASK;
   assign y_m = req_data.pixel_y & CMASK;

   logic [CW-1:0] half_w, half_h;
   logic [SW-1:0] far_w, far_h;
   logic [CW-1:0] dx_c, dy_c;
   assign half_w = w_eff[SW-1:1];
   assign half_h = h_eff[SW-1:1];
   assign far_w  = w_eff - {1'b0, half_w};
   assign far_h  = h_eff - {1'b0, half_h};
   assign dx_c = (x_m <= half_w) ? half_w - x_m : CW'({1'b0, x_m} - far_w);
   assign dy_c = (y_m <= half_h) ? half_h - y_m : CW'({1'b0, y_m} - far_h);

   logic          vert;
   logic [CW-1:0] c_c;
   logic [SW-1:0] span_c;
   assign vert   = (fill_mode_ff == MODE_TOP_BOTTOM) || (fill_mode_ff == MODE_BOTTOM_TOP);
   assign c_c    = vert ? y_m : x_m;
   assign span_c = vert ? h_eff - SW'(1) : w_eff - SW'(1);

   logic          s0_valid_ff;
   logic [2:0]    s0_mode_ff;
   logic [CW-1:0] s0_c_ff, s0_dx_ff, s0_dy_ff;
   logic [SW-1:0] s0_span_ff;

   // Stage 1: squares of the offsets.
   logic            s1_valid_ff;
   logic [2:0]      s1_mode_ff;
   logic [CW-1:0]   s1_c_ff;
   logic [SW-1:0]   s1_span_ff;
   logic [2*CW-1:0] s1_dx2_ff, s1_dy2_ff;

   // Stage 2: squared distance.
   logic          s2_valid_ff;
   logic [2:0]    s2_mode_ff;
   logic [CW-1:0] s2_c_ff;
   logic [SW-1:0] s2_span_ff;
   logic [2*CW:0] s2_dsq_ff;

   // Stage 3: dividend and divisor for either mode.
   logic             s3_valid_ff;
   logic [2:0]       s3_mode_ff;
   logic [DEN_W-1:0] s3_num_ff, s3_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s0_mode_ff <= fill_mode_ff;
      s0_c_ff    <= c_c;
      s0_span_ff <= span_c;
      s0_dx_ff   <= dx_c;
      s0_dy_ff   <= dy_c;

      s1_mode_ff <= s0_mode_ff;
      s1_c_ff    <= s0_c_ff;
      s1_span_ff <= s0_span_ff;
      s1_dx2_ff  <= (2*CW)'(s0_dx_ff) * (2*CW)'(s0_dx_ff);
      s1_dy2_ff  <= (2*CW)'(s0_dy_ff) * (2*CW)'(s0_dy_ff);

      s2_mode_ff <= s1_mode_ff;
      s2_c_ff    <= s1_c_ff;
      s2_span_ff <= s1_span_ff;
      s2_dsq_ff  <= (2*CW+1)'(s1_dx2_ff) + (2*CW+1)'(s1_dy2_ff);

      s3_mode_ff <= s2_mode_ff;
      if (s2_mode_ff == MODE_RADIAL) begin
         s3_num_ff <= DEN_W'(s2_dsq_ff) * DEN_W'(14'd10000);
         s3_den_ff <= rden_ff;
      end else begin
         s3_num_ff <= DEN_W'(s2_c_ff);
         s3_den_ff <= DEN_W'(s2_span_ff);
      end
   end

   // A zero span gives t = 0; a dividend at or past the divisor saturates
   // t at 1.0. Either way the divider is fed zero and its result unused.
   side_type         div_side;
   logic [DEN_W-1:0] div_num;
   assign div_side.mode   = s3_mode_ff;
   assign div_side.t_zero = (s3_den_ff == '0);
   assign div_side.t_one  = (s3_den_ff != '0) && (s3_num_ff >= s3_den_ff);
   assign div_num = (div_side.t_zero || div_side.t_one) ? '0 : s3_num_ff;

   logic             dv_valid;
   logic [QUO_W-1:0] dv_quo;
   side_type         dv_side;

   gbp_div_pipe #(
      .STEPS (QUO_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_num    (div_num),
      .in_den    (s3_den_ff),
      .in_side   (div_side),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // The linear quotient is the top half of the 32-bit quotient; the radial
   // factor is the square root of the full quotient.
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   logic [QUO_W-1:0]  sq_val;
   side_type          sq_side;

   gbp_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_valid),
      .in_val    (dv_quo),
      .in_side   (dv_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_val   (sq_val),
      .out_side  (sq_side)
   );

   // Blend factor stage.
   logic [T_W-1:0] t_c;
   always_comb begin
      if (sq_side.t_one) begin
         t_c = T_ONE;
      end else if (sq_side.t_zero) begin
         t_c = '0;
      end else if (sq_side.mode == MODE_RADIAL) begin
         t_c = T_W'(sq_root);
      end else begin
         t_c = T_W'(sq_val[QUO_W-1 -: ROOT_W]);
      end
   end

   logic           t_valid_ff;
   logic [2:0]     t_mode_ff;
   logic [T_W-1:0] t_ff;

   // Top-bottom and right-left swap the two gradient colors.
   logic             swap;
   logic [RGB_W-1:0] col_a, col_b;
   logic [T_W-1:0]   t_inv;
   assign swap  = (t_mode_ff == MODE_TOP_BOTTOM) || (t_mode_ff == MODE_RIGHT_LEFT);
   assign col_a = swap ? second_ff : first_ff;
   assign col_b = swap ? first_ff : second_ff;
   assign t_inv = T_ONE - t_ff;

   // Product stage: a*(1-t) and b*t for each channel.
   logic                p_valid_ff;
   logic [2:0]          p_mode_ff;
   logic [8+T_W-1:0]    pa_ff [3];
   logic [8+T_W-1:0]    pb_ff [3];

   // Output stage.
   logic    rsp_strobe_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff    <= 1'b0;
         p_valid_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         t_valid_ff    <= sq_valid;
         p_valid_ff    <= t_valid_ff;
         rsp_strobe_ff <= p_valid_ff;
      end
   end

   logic [8+T_W-1:0] acc [3];
   logic             solid;
   assign solid = (p_mode_ff < MODE_TOP_BOTTOM) || (p_mode_ff > MODE_RADIAL);
   for (genvar ch = 0; ch < 3; ch++) begin : g_acc
      assign acc[ch] = pa_ff[ch] + pb_ff[ch];
   end

   always_ff @(posedge clock) begin
      t_mode_ff <= sq_side.mode;
      t_ff      <= t_c;
      p_mode_ff <= t_mode_ff;
      for (int ch = 0; ch < 3; ch++) begin
         pa_ff[ch] <= (8+T_W)'(col_a[RGB_W-1-8*ch -: 8]) * (8+T_W)'(t_inv);
         pb_ff[ch] <= (8+T_W)'(col_b[RGB_W-1-8*ch -: 8]) * (8+T_W)'(t_ff);
      end
      if (solid) begin
         rsp_data_ff.red   <= solid_ff[23:16];
         rsp_data_ff.green <= solid_ff[15:8];
         rsp_data_ff.blue  <= solid_ff[7:0];
      end else begin
         rsp_data_ff.red   <= acc[0][23:16];
         rsp_data_ff.green <= acc[1][23:16];
         rsp_data_ff.blue  <= acc[2][23:16];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // Reset empties the pipeline, so no result follows it.
   assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   // The blend factor never exceeds 1.0.
   assert property (@(posedge clock) disable iff (reset)
      t_valid_ff |-> t_ff <= T_ONE)
      else $error("blend factor above one");

   // A request cannot be both a zero span and a saturated one.
   assert property (@(posedge clock) disable iff (reset)
      sq_valid |-> !(sq_side.t_zero && sq_side.t_one))
      else $error("conflicting blend factor flags");

endmodule
